>>> design/dedup_match_table_with_drain_unit_macros.svh
// Assertion macros shared by the rule-match table modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef DEDUP_MATCH_TABLE_WITH_DRAIN_UNIT_MACROS_SVH
`define DEDUP_MATCH_TABLE_WITH_DRAIN_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DMT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/dmt_pkg.sv
// Types and constants of the rule-match table with per-phase drain.
// Depends on nothing; used by the top level, the controller, the datapath and the testbench.
package dmt_pkg;

   localparam int DMT_MAX_ENTRIES = 16;
   localparam int DMT_ID_BYTES    = 16;
   localparam int DMT_ID_W        = 128;
   localparam int DMT_RULE_W      = 40;
   localparam int DMT_PHASE_W     = 3;
   localparam int DMT_LEN_W       = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 64;

   localparam logic [DMT_RULE_W-1:0]  DMT_RULE_MAX  = 40'd999999999999;
   localparam logic [DMT_PHASE_W-1:0] DMT_PHASE_MAX = 3'd4;

   typedef enum logic [1:0] {
      FN_CAPTURE = 2'd0,
      FN_NEXT    = 2'd1,
      FN_FAIL    = 2'd2
   } dmt_func_type;

   typedef enum logic [1:0] {
      RS_NONE  = 2'd0,
      RS_ENTRY = 2'd1,
      RS_ERROR = 2'd2
   } dmt_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED   = 2'd0,
      CSR_ID_HIGH   = 2'd1,
      CSR_ID_LOW    = 2'd2,
      CSR_ID_LENGTH = 2'd3
   } dmt_csr_type;

   typedef struct packed {
      logic [DMT_RULE_W-1:0]  rule;
      logic [DMT_PHASE_W-1:0] phase;
      logic                   emitted;
   } dmt_entry_type;

   typedef struct packed {
      logic           load;
      logic           scan_start;
      logic           scan_run;
      logic           append;
      logic           mark;
      logic           set_fail;
      logic           finish;
      logic           use_rule;
      dmt_status_type status;
   } dmt_cmd_type;

   typedef struct packed {
      dmt_func_type func;
      logic         enabled;
      logic         failed;
      logic         item_ok;
      logic         phase_ok;
      logic         count_zero;
      logic         full;
      logic         out_empty;
      logic         hit;
      logic         last;
   } dmt_stat_type;

endpackage

>>> design/dmt_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; instantiated around the top level.
interface dmt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [63:0]        txn_id_high;
   logic [63:0]        txn_id_low;
   logic [4:0]         txn_id_length;
   logic signed [40:0] rule_number;
   logic [2:0]         phase;

   modport source (output valid, func, txn_id_high, txn_id_low, txn_id_length,
                   rule_number, phase, input ready);
   modport sink (input valid, func, txn_id_high, txn_id_low, txn_id_length,
                 rule_number, phase, output ready);
endinterface

interface dmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [39:0] rule_out;
   logic        failed_flag;

   modport source (output valid, status, rule_out, failed_flag, input ready);
   modport sink (input valid, status, rule_out, failed_flag, output ready);
endinterface

>>> design/dedup_match_table_with_drain_unit.sv
// Channel    Direction  Transfer                 Carries
// req_chan   in         valid and ready high     func, ID words and length, rule, phase
// rsp_chan   out        valid and ready high     status, rule_out, failed_flag
// csr_*      in         csr_we high              register index and 64-bit write data
//
// A transaction is taken in ST_IDLE and registered, then evaluated in ST_EVAL. A table scan
// then reads one entry per cycle from the single read port of the entry memory. A transaction
// holds the block through its evaluation and any scan before the next one is taken.
// A new transaction is accepted while the previous result still waits on rsp_chan;
// its evaluation holds until that result has been taken.
// Reset is synchronous and active high; it resets the table count, the failure latch
// and the control registers. Entry contents are not cleared, as only filled entries are read.
// Top level of the rule-match table; depends on dmt_pkg, dmt_if, dmt_ctrl and dmt_datapath.
module dedup_match_table_with_drain_unit #(
   parameter int MAX_ENTRIES = dmt_pkg::DMT_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   dmt_req_if.sink                        req_chan,
   dmt_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [dmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dmt_pkg::*;

   dmt_cmd_type  cmd;
   dmt_stat_type stat;

   dmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dmt_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_chan.func),
      .req_txn_id_high   (req_chan.txn_id_high),
      .req_txn_id_low    (req_chan.txn_id_low),
      .req_txn_id_length (req_chan.txn_id_length),
      .req_rule_number   (req_chan.rule_number),
      .req_phase         (req_chan.phase),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_rule_out      (rsp_chan.rule_out),
      .rsp_failed_flag   (rsp_chan.failed_flag)
   );

endmodule

>>> design/dmt_datapath.sv
// Datapath: registers, ID and range checks, entry memory, scan pipeline, result register.
// Depends on dmt_pkg and the assertion macro header.
`include "dedup_match_table_with_drain_unit_macros.svh"

module dmt_datapath #(
   parameter int MAX_ENTRIES = dmt_pkg::DMT_MAX_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dmt_pkg::dmt_cmd_type                cmd,
   output dmt_pkg::dmt_stat_type               stat,
   input  logic [1:0]                          req_func,
   input  logic [63:0]                         req_txn_id_high,
   input  logic [63:0]                         req_txn_id_low,
   input  logic [4:0]                          req_txn_id_length,
   input  logic signed [40:0]                  req_rule_number,
   input  logic [2:0]                          req_phase,
   input  logic                                csr_we,
   input  logic [dmt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [39:0]                         rsp_rule_out,
   output logic                                rsp_failed_flag
);
   import dmt_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic                   enabled_ff;
   logic [63:0]            exp_hi_ff;
   logic [63:0]            exp_lo_ff;
   logic [DMT_LEN_W-1:0]   exp_len_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic                   fail_ff, fail_in;

   logic [1:0]             func_ff;
   logic [DMT_RULE_W-1:0]  item_rule_ff;
   logic [DMT_PHASE_W-1:0] phase_ff;
   logic                   item_ok_ff;
   logic                   phase_ok_ff;

   logic [DMT_ID_W-1:0]    id_in;
   logic [DMT_ID_W-1:0]    id_exp;
   logic                   id_ok;
   logic                   rule_ok;
   logic                   phase_ok;

   dmt_entry_type          mem [MAX_ENTRIES];
   dmt_entry_type          rdata_ff;
   dmt_entry_type          wdata;
   logic                   mem_we;
   logic [AW-1:0]          waddr;
   logic [CW-1:0]          scan_addr_ff;
   logic                   issue;
   logic                   rd_valid_ff;
   logic [AW-1:0]          rd_idx_ff;
   logic                   hit;
   logic                   last;
   logic                   csr_clear;

   logic                   rsp_valid_ff;
   dmt_status_type         status_ff;
   logic [DMT_RULE_W-1:0]  rule_out_ff;
   logic                   failed_ff;

   assign id_in  = {req_txn_id_high, req_txn_id_low};
   assign id_exp = {exp_hi_ff, exp_lo_ff};

   // Bytes run from the top of the 128-bit word; only the first length bytes count.
   always_comb begin
      id_ok = (req_txn_id_length == exp_len_ff) && (exp_len_ff != '0) &&
              (exp_len_ff <= DMT_LEN_W'(DMT_ID_BYTES));
      for (int i = 0; i < DMT_ID_W / 8; i++) begin
         if ((DMT_LEN_W'(i) < req_txn_id_length) &&
             (id_in[DMT_ID_W-1-8*i -: 8] != id_exp[DMT_ID_W-1-8*i -: 8])) begin
            id_ok = 1'b0;
         end
      end
   end

   assign rule_ok  = !req_rule_number[40] && (req_rule_number[39:0] != '0) &&
                     (req_rule_number[39:0] <= DMT_RULE_MAX);
   assign phase_ok = (req_phase <= DMT_PHASE_MAX);

   assign csr_clear = csr_we && (dmt_csr_type'(csr_index) == CSR_ENABLED);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         exp_hi_ff  <= '0;
         exp_lo_ff  <= '0;
         exp_len_ff <= DMT_LEN_W'(1);
      end else if (csr_we) begin
         case (dmt_csr_type'(csr_index))
            CSR_ENABLED:   enabled_ff <= csr_wdata[0];
            CSR_ID_HIGH:   exp_hi_ff  <= csr_wdata;
            CSR_ID_LOW:    exp_lo_ff  <= csr_wdata;
            CSR_ID_LENGTH: exp_len_ff <= csr_wdata[DMT_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      fail_in  = fail_ff;
      if (csr_clear) begin
         count_in = '0;
         fail_in  = 1'b0;
      end else begin
         if (cmd.append) begin
            count_in = count_ff + CW'(1);
         end
         if (cmd.set_fail) begin
            fail_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         fail_ff  <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_func;
         item_rule_ff <= req_rule_number[39:0];
         phase_ff     <= req_phase;
         item_ok_ff   <= id_ok && rule_ok && phase_ok;
         phase_ok_ff  <= phase_ok;
      end
   end

   // Scan pipeline: one address issued per cycle, compared when its data returns.
   assign issue = cmd.scan_run && (scan_addr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         if (issue) begin
            scan_addr_ff <= scan_addr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff  <= mem[scan_addr_ff[AW-1:0]];
         rd_idx_ff <= scan_addr_ff[AW-1:0];
      end
   end

   always_comb begin
      mem_we = cmd.append || cmd.mark;
      if (cmd.mark) begin
         waddr         = rd_idx_ff;
         wdata         = rdata_ff;
         wdata.emitted = 1'b1;
      end else begin
         waddr = count_ff[AW-1:0];
         wdata = '{rule: item_rule_ff, phase: phase_ff, emitted: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
   end

   // A capture looks for the same rule and phase; a fetch for the oldest unemitted entry of that phase.
   assign hit = rd_valid_ff && (rdata_ff.phase == phase_ff) &&
                ((dmt_func_type'(func_ff) == FN_NEXT) ? !rdata_ff.emitted
                                                      : (rdata_ff.rule == item_rule_ff));
   assign last = rd_valid_ff && ((CW'(rd_idx_ff) + CW'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff   <= cmd.status;
         rule_out_ff <= cmd.use_rule ? rdata_ff.rule : '0;
         failed_ff   <= fail_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_rule_out    = rule_out_ff;
   assign rsp_failed_flag = failed_ff;

   always_comb begin
      stat            = '0;
      stat.func       = dmt_func_type'(func_ff);
      stat.enabled    = enabled_ff;
      stat.failed     = fail_ff;
      stat.item_ok    = item_ok_ff;
      stat.phase_ok   = phase_ok_ff;
      stat.count_zero = (count_ff == '0);
      stat.full       = (count_ff == CW'(MAX_ENTRIES));
      stat.out_empty  = !rsp_valid_ff;
      stat.hit        = hit;
      stat.last       = last;
   end

   `DMT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_ENTRIES), "entry count above table depth")
   `DMT_ASSERT_IMP(a_append_room, clock, reset, cmd.append, count_ff < CW'(MAX_ENTRIES), "append into a full table")
   `DMT_ASSERT_IMP(a_mark_on_hit, clock, reset, cmd.mark, hit, "entry marked without a matching read")
   `DMT_ASSERT_IMP(a_result_free, clock, reset, cmd.finish, !rsp_valid_ff, "result overwrites a pending result")

endmodule

>>> design/dmt_ctrl.sv
// Controller: sequences each transaction through evaluation and the table scan.
// Depends on dmt_pkg and the assertion macro header.
`include "dedup_match_table_with_drain_unit_macros.svh"

module dmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dmt_pkg::dmt_stat_type stat,
   output dmt_pkg::dmt_cmd_type  cmd
);
   import dmt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         // Decisions wait until the previous result has been taken.
         ST_EVAL: begin
            if (stat.out_empty) begin
               cmd.finish = 1'b1;
               cmd.status = RS_NONE;
               case (stat.func)
                  FN_CAPTURE: begin
                     if (stat.enabled && !stat.failed) begin
                        if (!stat.item_ok) begin
                           cmd.set_fail = 1'b1;
                           cmd.status   = RS_ERROR;
                        end else if (stat.count_zero) begin
                           cmd.append = 1'b1;
                        end else begin
                           cmd.finish     = 1'b0;
                           cmd.scan_start = 1'b1;
                        end
                     end
                  end
                  FN_NEXT: begin
                     if (stat.enabled) begin
                        if (stat.failed) begin
                           cmd.status = RS_ERROR;
                        end else if (!stat.phase_ok) begin
                           cmd.set_fail = 1'b1;
                           cmd.status   = RS_ERROR;
                        end else if (!stat.count_zero) begin
                           cmd.finish     = 1'b0;
                           cmd.scan_start = 1'b1;
                        end
                     end
                  end
                  FN_FAIL: begin
                     cmd.set_fail = 1'b1;
                     cmd.status   = RS_ERROR;
                  end
                  default: begin
                  end
               endcase
               state_in = cmd.finish ? ST_IDLE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.finish = 1'b1;
               if (stat.func == FN_NEXT) begin
                  cmd.mark     = 1'b1;
                  cmd.use_rule = 1'b1;
                  cmd.status   = RS_ENTRY;
               end else begin
                  cmd.status = RS_NONE;
               end
               state_in = ST_IDLE;
            end else if (stat.last) begin
               cmd.finish = 1'b1;
               cmd.status = RS_NONE;
               if (stat.func == FN_CAPTURE) begin
                  if (stat.full) begin
                     cmd.set_fail = 1'b1;
                     cmd.status   = RS_ERROR;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DMT_ASSERT_IMP(a_entry_marks, clock, reset, cmd.finish && cmd.status == RS_ENTRY, cmd.mark, "entry returned without being marked")
   `DMT_ASSERT_IMP(a_scan_ends, clock, reset, state_ff == ST_SCAN && stat.last, cmd.finish, "scan ran past the last entry")
   `DMT_ASSERT_NXT(a_result_shown, clock, reset, cmd.finish, !stat.out_empty, "finished transaction left no result")

endmodule

>>> tb/sv/dedup_match_table_with_drain_unit_tb.sv
// Self-checking testbench of the rule-match table with per-phase drain.
// Depends on dmt_pkg, dmt_if and dedup_match_table_with_drain_unit; predicts every
// response in step with the accepted requests and compares each one field by field.
module dedup_match_table_with_drain_unit_tb;
   import dmt_pkg::*;

   localparam int         STALL_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = DMT_MAX_ENTRIES + 8;
   localparam int         HOLD_CYCLES   = 150;
   localparam int         RANDOM_ITEMS  = 580;
   localparam logic [1:0] FN_UNUSED     = 2'd3;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] id_hi;
      logic [63:0] id_lo;
      logic [4:0]  id_len;
      logic [40:0] rule;
      logic [2:0]  phase;
   } match_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [39:0] rule;
      logic        failed;
   } match_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dmt_req_if req_chan ();
   dmt_rsp_if rsp_chan ();

   dedup_match_table_with_drain_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted copy of the registers and of the match table.
   logic              cfg_en     = 1'b0;
   logic [63:0]       cfg_hi     = '0;
   logic [63:0]       cfg_lo     = '0;
   logic [4:0]        cfg_len    = 5'd1;
   logic [39:0]       tab_rule  [DMT_MAX_ENTRIES];
   logic [2:0]        tab_phase [DMT_MAX_ENTRIES];
   logic              tab_done  [DMT_MAX_ENTRIES];
   int                tab_count  = 0;
   logic              fail_latch = 1'b0;

   match_rsp_type     owed_outcomes[$];
   int                mismatch_count = 0;
   bit                idle_on = 1'b1;
   bit                burst   = 1'b0;
   int                hold_len = 0;

   function automatic logic [127:0] lead_mask(int nbytes);
      if (nbytes >= DMT_ID_BYTES) return '1;
      return ~({128{1'b1}} >> (8 * nbytes));
   endfunction

   function automatic bit id_hits(match_req_type rq);
      logic [127:0] diff;
      if (rq.id_len != cfg_len || cfg_len < 1 || cfg_len > DMT_ID_BYTES) return 1'b0;
      diff = {rq.id_hi, rq.id_lo} ^ {cfg_hi, cfg_lo};
      return (diff & lead_mask(int'(cfg_len))) == '0;
   endfunction

   function automatic match_rsp_type match_table_step(match_req_type rq);
      match_rsp_type o;
      logic [39:0]   mag;
      bit            dup;
      bit            found;
      int            i;
      o.status = RS_NONE;
      o.rule   = '0;
      mag      = rq.rule[39:0];
      dup      = 1'b0;
      found    = 1'b0;
      case (rq.func)
         FN_CAPTURE: begin
            if (cfg_en && !fail_latch) begin
               if (!id_hits(rq) || rq.rule[40] || mag == '0 || mag > DMT_RULE_MAX
                   || rq.phase > DMT_PHASE_MAX) begin
                  fail_latch = 1'b1;
                  o.status   = RS_ERROR;
               end else begin
                  for (i = 0; i < tab_count; i++)
                     if (tab_phase[i] == rq.phase && tab_rule[i] == mag) dup = 1'b1;
                  if (!dup) begin
                     if (tab_count >= DMT_MAX_ENTRIES) begin
                        fail_latch = 1'b1;
                        o.status   = RS_ERROR;
                     end else begin
                        tab_rule[tab_count]  = mag;
                        tab_phase[tab_count] = rq.phase;
                        tab_done[tab_count]  = 1'b0;
                        tab_count++;
                     end
                  end
               end
            end
         end
         FN_NEXT: begin
            if (!cfg_en) begin
               o.status = RS_NONE;
            end else if (fail_latch) begin
               o.status = RS_ERROR;
            end else if (rq.phase > DMT_PHASE_MAX) begin
               fail_latch = 1'b1;
               o.status   = RS_ERROR;
            end else begin
               for (i = 0; i < tab_count && !found; i++) begin
                  if (tab_phase[i] == rq.phase && !tab_done[i]) begin
                     tab_done[i] = 1'b1;
                     o.status    = RS_ENTRY;
                     o.rule      = tab_rule[i];
                     found       = 1'b1;
                  end
               end
            end
         end
         FN_FAIL: begin
            fail_latch = 1'b1;
            o.status   = RS_ERROR;
         end
         default: ;
      endcase
      o.failed = fail_latch;
      return o;
   endfunction

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_request(match_req_type rq);
      int gap;
      gap = (idle_on && !burst) ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.func          = rq.func;
      req_chan.txn_id_high   = rq.id_hi;
      req_chan.txn_id_low    = rq.id_lo;
      req_chan.txn_id_length = rq.id_len;
      req_chan.rule_number   = rq.rule;
      req_chan.phase         = rq.phase;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      owed_outcomes.push_back(match_table_step(rq));
   endtask

   // Waits until every response is back and the block has had time to go idle.
   task automatic quiesce();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (owed_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(dmt_csr_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         CSR_ENABLED: begin
            cfg_en     = val[0];
            tab_count  = 0;
            fail_latch = 1'b0;
         end
         CSR_ID_HIGH:   cfg_hi  = val;
         CSR_ID_LOW:    cfg_lo  = val;
         CSR_ID_LENGTH: cfg_len = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(logic en, logic [63:0] hi, logic [63:0] lo, logic [4:0] len);
      quiesce();
      write_reg(CSR_ID_HIGH, hi);
      write_reg(CSR_ID_LOW, lo);
      write_reg(CSR_ID_LENGTH, 64'(len));
      write_reg(CSR_ENABLED, 64'(en));
   endtask

   task automatic rearm();
      quiesce();
      write_reg(CSR_ENABLED, 64'(1'b1));
   endtask

   // A request whose ID matches the programmed one; bytes past the length are random.
   function automatic match_req_type matching_req(logic [1:0] f, logic [40:0] rule,
                                                  logic [2:0] ph);
      match_req_type rq;
      logic [127:0]  mask;
      logic [127:0]  id;
      mask      = lead_mask(int'(cfg_len));
      id        = ({cfg_hi, cfg_lo} & mask)
                  | ({$urandom, $urandom, $urandom, $urandom} & ~mask);
      rq.func   = f;
      rq.id_hi  = id[127:64];
      rq.id_lo  = id[63:0];
      rq.id_len = cfg_len;
      rq.rule   = rule;
      rq.phase  = ph;
      return rq;
   endfunction

   function automatic logic [40:0] rand_valid_rule();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return 41'(r % 64'(DMT_RULE_MAX) + 64'd1);
   endfunction

   task automatic check_response();
      match_rsp_type want;
      if (owed_outcomes.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      want = owed_outcomes.pop_front();
      if (rsp_chan.status !== want.status)
         report($sformatf("status %0d, wanted %0d", rsp_chan.status, want.status));
      if (rsp_chan.rule_out !== want.rule)
         report($sformatf("rule_out %0d, wanted %0d", rsp_chan.rule_out, want.rule));
      if (rsp_chan.failed_flag !== want.failed)
         report($sformatf("failed_flag %b, wanted %b", rsp_chan.failed_flag, want.failed));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_response();
   end

   // Response side: a random pause per transaction while idle_on is set, or a long hold when one is requested.
   initial begin : response_side
      int pause;
      forever begin
         pause = idle_on ? $urandom_range(0, 12) : 0;
         if (hold_len != 0) begin
            pause    = hold_len;
            hold_len = 0;
         end
         @(negedge clock);
         if (pause != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
          || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("dedup_match_table_with_drain_unit_tb: errors");
            $finish;
         end
      end
   end

   // After reset the block is disabled: captures and next requests do nothing,
   // while a forced failure still latches.
   task automatic test_disabled_block();
      send_request(matching_req(FN_CAPTURE, 41'd1, 3'd0));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd0));
      send_request(matching_req(FN_UNUSED, 41'd5, 3'd1));
      send_request(matching_req(FN_FAIL, 41'd0, 3'd0));
   endtask

   task automatic test_capture_and_drain();
      configure(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 5'd16);
      send_request(matching_req(FN_CAPTURE, 41'd1, 3'd0));
      send_request(matching_req(FN_CAPTURE, {1'b0, DMT_RULE_MAX}, DMT_PHASE_MAX));
      send_request(matching_req(FN_CAPTURE, 41'd1, 3'd0));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd0));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd0));
      send_request(matching_req(FN_NEXT, 41'd0, DMT_PHASE_MAX));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd2));
      send_request(matching_req(FN_UNUSED, 41'd0, 3'd0));
      send_request(matching_req(FN_CAPTURE, 41'd0, 3'd1));
      send_request(matching_req(FN_CAPTURE, 41'd7, 3'd1));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd1));
   endtask

   // Each malformed request latches the failure, so the table is re-armed in between.
   task automatic test_rejected_requests();
      match_req_type rq;
      rearm();
      send_request(matching_req(FN_CAPTURE, {1'b1, 40'd0}, 3'd0));
      rearm();
      send_request(matching_req(FN_CAPTURE, {1'b0, DMT_RULE_MAX} + 41'd1, 3'd0));
      rearm();
      send_request(matching_req(FN_CAPTURE, 41'd3, 3'd7));
      rearm();
      send_request(matching_req(FN_NEXT, 41'd0, 3'd5));
      rearm();
      rq        = matching_req(FN_CAPTURE, 41'd3, 3'd0);
      rq.id_len = 5'd15;
      send_request(rq);
      rearm();
      rq             = matching_req(FN_CAPTURE, 41'd3, 3'd0);
      rq.id_lo[7:0]  = rq.id_lo[7:0] ^ 8'h01;
      send_request(rq);
      rearm();
      rq        = matching_req(FN_CAPTURE, 41'd3, 3'd0);
      rq.id_len = 5'd0;
      send_request(rq);
   endtask

   // An expected length outside one to sixteen bytes can never be matched.
   task automatic test_expected_length_limits();
      configure(1'b1, 64'hAB00_0000_0000_0000, 64'd0, 5'd1);
      send_request(matching_req(FN_CAPTURE, 41'd42, 3'd2));
      configure(1'b1, 64'hAB00_0000_0000_0000, 64'd0, 5'd0);
      send_request(matching_req(FN_CAPTURE, 41'd42, 3'd2));
      configure(1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
      send_request(matching_req(FN_CAPTURE, 41'd42, 3'd2));
   endtask

   task automatic test_table_overflow();
      int i;
      configure(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(1, DMT_ID_BYTES)));
      for (i = 0; i < DMT_MAX_ENTRIES; i++)
         send_request(matching_req(FN_CAPTURE, 41'(1000 + i), 3'($urandom_range(0, 4))));
      send_request(matching_req(FN_CAPTURE, 41'd1000, tab_phase[0]));
      send_request(matching_req(FN_CAPTURE, 41'd999, 3'd0));
      send_request(matching_req(FN_NEXT, 41'd0, 3'd0));
   endtask

   // The response side holds off while requests keep coming, so the input backs up.
   task automatic test_back_pressure();
      int i;
      rearm();
      hold_len = HOLD_CYCLES;
      burst    = 1'b1;
      for (i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            send_request(matching_req(FN_NEXT, 41'd0, 3'($urandom_range(0, 4))));
         else
            send_request(matching_req(FN_CAPTURE, 41'($urandom_range(1, 6)),
                                      3'($urandom_range(0, 4))));
      end
      burst = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [40:0]   pool[12];
      match_req_type rq;
      int            done;
      int            seg_len;
      int            i;
      int            r;
      int            pos;
      logic [63:0]   hi;
      logic [63:0]   lo;
      logic [4:0]    len;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         r  = $urandom_range(0, 9);
         hi = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
         r  = $urandom_range(0, 9);
         lo = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
         r  = $urandom_range(0, 19);
         if (r == 0)
            len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
         else if (r == 1)
            len = 5'd16;
         else if (r == 2)
            len = 5'd1;
         else
            len = 5'($urandom_range(1, 16));
         configure($urandom_range(0, 9) != 0, hi, lo, len);
         idle_on = $urandom_range(0, 3) != 0;
         pool[0] = 41'd1;
         pool[1] = {1'b0, DMT_RULE_MAX};
         for (i = 2; i < 12; i++) pool[i] = rand_valid_rule();
         seg_len = $urandom_range(20, 50);
         for (i = 0; i < seg_len && done < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rq = matching_req(FN_CAPTURE, pool[$urandom_range(0, 11)],
                                 3'($urandom_range(0, 4)));
            end else if (r < 88) begin
               rq = matching_req(FN_NEXT, 41'({$urandom, $urandom}),
                                 3'((r < 86) ? $urandom_range(0, 4) : $urandom_range(5, 7)));
            end else if (r < 90) begin
               rq = matching_req(FN_FAIL, 41'({$urandom, $urandom}),
                                 3'($urandom_range(0, 7)));
            end else if (r < 92) begin
               rq = matching_req(FN_UNUSED, 41'({$urandom, $urandom}),
                                 3'($urandom_range(0, 7)));
            end else begin
               rq = matching_req(FN_CAPTURE, pool[$urandom_range(0, 11)],
                                 3'($urandom_range(0, 4)));
               case ($urandom_range(0, 5))
                  0: begin
                     if (cfg_len >= 1 && cfg_len <= DMT_ID_BYTES) begin
                        pos = $urandom_range(0, int'(cfg_len) - 1);
                        {rq.id_hi, rq.id_lo} = {rq.id_hi, rq.id_lo}
                           ^ (128'($urandom_range(1, 255)) << (8 * (15 - pos)));
                     end
                  end
                  1: rq.id_len = 5'($urandom_range(0, 31));
                  2: rq.rule   = 41'({$urandom, $urandom});
                  3: rq.rule   = {1'b1, 8'($urandom), 32'($urandom)};
                  4: rq.rule   = ($urandom_range(0, 1) == 0) ? 41'd0
                                 : {1'b0, DMT_RULE_MAX} + 41'($urandom_range(1, 1000));
                  default: rq.phase = 3'($urandom_range(5, 7));
               endcase
            end
            send_request(rq);
            done++;
            // Once latched there is little left to exercise in this setting.
            if (fail_latch && $urandom_range(0, 3) == 0) break;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_ENABLED;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FN_CAPTURE;
      req_chan.txn_id_high   = '0;
      req_chan.txn_id_low    = '0;
      req_chan.txn_id_length = '0;
      req_chan.rule_number   = '0;
      req_chan.phase         = '0;
      rsp_chan.ready         = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_block();
      test_capture_and_drain();
      test_rejected_requests();
      test_expected_length_limits();
      test_table_overflow();
      test_back_pressure();
      test_random_traffic();
      configure(1'b0, 64'd0, 64'd0, 5'd1);
      quiesce();

      if (mismatch_count == 0)
         $display("dedup_match_table_with_drain_unit_tb: clean");
      else
         $display("dedup_match_table_with_drain_unit_tb: errors");
      $finish;
   end

endmodule
